@@ design/tcw_pkg.sv @@
// Shared types, palette tables and register codes for the text cell writer.
package tcw_pkg;

  // Lane and merge geometry: one lane per palette entry, merged in groups of four
  localparam int unsigned NumLanes   = 16;
  localparam int unsigned GroupSize  = 4;
  localparam int unsigned NumGroups  = NumLanes / GroupSize;

  localparam int unsigned DistW = 18;
  localparam int unsigned IdxW  = 4;

  typedef logic [DistW-1:0] dist_t;
  typedef logic [IdxW-1:0]  pal_idx_t;

  // Fixed 16-entry palette as 0xRRGGBB
  localparam logic [23:0] PALETTE [NumLanes] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
    24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
    24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
    24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
  };

  // Palette entry to text-mode color index
  localparam logic [3:0] TEXT_INDEX [NumLanes] = '{
    4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7,
    4'd8, 4'd12, 4'd10, 4'd14, 4'd9, 4'd13, 4'd11, 4'd15
  };

  // Character substitution for codes outside one byte
  localparam logic [7:0] SUBST_CHAR = 8'h3F;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_COLUMNS     = 2'd0,
    CFG_ROWS        = 2'd1,
    CFG_ROW_PITCH   = 2'd2,
    CFG_BUFFER_BASE = 2'd3
  } cfg_reg_e;

  localparam logic [11:0] COLUMNS_RST     = 12'd80;
  localparam logic [11:0] ROWS_RST        = 12'd25;
  localparam logic [15:0] ROW_PITCH_RST   = 16'd160;
  localparam logic [31:0] BUFFER_BASE_RST = 32'd753664;

  typedef struct packed {
    logic [15:0] char_code;
    logic [11:0] column;
    logic [11:0] row;
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
  } in_item_t;

  typedef struct packed {
    logic [31:0] cell_address;
    logic [15:0] cell_word;
  } out_item_t;

  // One palette candidate: its distance and palette index
  typedef struct packed {
    dist_t    distance;
    pal_idx_t idx;
  } cand_t;

endpackage

@@ design/tcw_lane.sv @@
// One palette lane: registered squared RGB distance of both colors to one entry.
module tcw_lane import tcw_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [23:0] pal_rgb_i,
  input  logic [23:0] fore_rgb_i,
  input  logic [23:0] back_rgb_i,
  output dist_t       fore_dist_o,
  output dist_t       back_dist_o
);

  function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return {8'b0, d} * {8'b0, d};
  endfunction

  function automatic dist_t color_dist(input logic [23:0] c, input logic [23:0] p);
    return {2'b0, chan_sq(c[23:16], p[23:16])}
         + {2'b0, chan_sq(c[15:8], p[15:8])}
         + {2'b0, chan_sq(c[7:0], p[7:0])};
  endfunction

  dist_t fore_dist_q, back_dist_q;

  // Capture distances when the stage advances
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fore_dist_q <= color_dist(fore_rgb_i, pal_rgb_i);
      back_dist_q <= color_dist(back_rgb_i, pal_rgb_i);
    end
  end

  assign fore_dist_o = fore_dist_q;
  assign back_dist_o = back_dist_q;

endmodule

@@ design/tcw_merge.sv @@
// Four-way minimum select; on a tie the earlier candidate wins.
module tcw_merge import tcw_pkg::*; (
  input  cand_t [GroupSize-1:0] cand_i,
  output cand_t                 best_o
);

  cand_t lo, hi;

  // Pairwise compare, then compare the two winners
  always_comb begin
    lo     = (cand_i[1].distance < cand_i[0].distance) ? cand_i[1] : cand_i[0];
    hi     = (cand_i[3].distance < cand_i[2].distance) ? cand_i[3] : cand_i[2];
    best_o = (hi.distance < lo.distance) ? hi : lo;
  end

endmodule

@@ design/text_cell_writer.sv @@
// Top level of the text cell writer: config registers, lanes, merge pipeline.
//
//   channel  | direction | handshake                | payload
//   in       | input     | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
//   out      | output    | out_valid_o / out_stall_i| out_item_o (out_item_t)
//   cfg      | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// Four stages: input register, lane distances and row product, group minimum
// and address sum, final minimum into the output register.
// One item per cycle while out_stall_i is low; out_valid_o marks stage four.
// Stages advance independently, so bubbles collapse under an output stall.
// Reset restores the register defaults and empties every stage.
// Out-of-range positions are dropped after the input register.
module text_cell_writer import tcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  cfg_reg_e  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [11:0] columns_q, rows_q;
  logic [15:0] row_pitch_q;
  logic [31:0] buffer_base_q;

  // Configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q     <= COLUMNS_RST;
      rows_q        <= ROWS_RST;
      row_pitch_q   <= ROW_PITCH_RST;
      buffer_base_q <= BUFFER_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COLUMNS:     columns_q     <= cfg_data_i[11:0];
        CFG_ROWS:        rows_q        <= cfg_data_i[11:0];
        CFG_ROW_PITCH:   row_pitch_q   <= cfg_data_i[15:0];
        CFG_BUFFER_BASE: buffer_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic hit;

  // Stage ready chain
  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  in_item_t item1_q;
  assign hit = (item1_q.column < columns_q) && (item1_q.row < rows_q);

  // Valid bits; drop out-of-range items between stage one and two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q && hit;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage one: input register
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) item1_q <= in_item_i;
  end

  // Stage two: lanes, character fixup and row product
  logic        en2;
  logic [7:0]  char2_q;
  logic [11:0] col2_q;
  logic [27:0] prod2_q;
  dist_t       fore_dist [NumLanes];
  dist_t       back_dist [NumLanes];

  assign en2 = rdy2 && v1_q;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    tcw_lane u_lane (
      .clk_i      (clk_i),
      .en_i       (en2),
      .pal_rgb_i  (PALETTE[l]),
      .fore_rgb_i (item1_q.fore_rgb),
      .back_rgb_i (item1_q.back_rgb),
      .fore_dist_o(fore_dist[l]),
      .back_dist_o(back_dist[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      char2_q <= (item1_q.char_code[15:8] != 8'd0) ? SUBST_CHAR : item1_q.char_code[7:0];
      col2_q  <= item1_q.column;
      prod2_q <= {16'b0, item1_q.row} * {12'b0, row_pitch_q};
    end
  end

  // Stage three: group minimums and address sum
  cand_t [GroupSize-1:0] fore_cand [NumGroups];
  cand_t [GroupSize-1:0] back_cand [NumGroups];
  cand_t [NumGroups-1:0] fore_grp_d, back_grp_d, fore_grp_q, back_grp_q;
  logic [31:0] addr3_q;
  logic [7:0]  char3_q;

  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    for (genvar k = 0; k < GroupSize; k++) begin : g_cand
      assign fore_cand[g][k].distance = fore_dist[g*GroupSize + k];
      assign fore_cand[g][k].idx      = pal_idx_t'(g*GroupSize + k);
      assign back_cand[g][k].distance = back_dist[g*GroupSize + k];
      assign back_cand[g][k].idx      = pal_idx_t'(g*GroupSize + k);
    end
    tcw_merge u_fore_grp (.cand_i(fore_cand[g]), .best_o(fore_grp_d[g]));
    tcw_merge u_back_grp (.cand_i(back_cand[g]), .best_o(back_grp_d[g]));
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      fore_grp_q <= fore_grp_d;
      back_grp_q <= back_grp_d;
      char3_q    <= char2_q;
      addr3_q    <= buffer_base_q + {4'b0, prod2_q} + {19'b0, col2_q, 1'b0};
    end
  end

  // Stage four: final minimum, color remap, output register
  cand_t     fore_best, back_best;
  out_item_t out_q;

  tcw_merge u_fore_fin (.cand_i(fore_grp_q), .best_o(fore_best));
  tcw_merge u_back_fin (.cand_i(back_grp_q), .best_o(back_best));

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_q.cell_address <= addr3_q;
      out_q.cell_word    <= {TEXT_INDEX[back_best.idx], TEXT_INDEX[fore_best.idx], char3_q};
    end
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = out_q;

  // An out-of-range item never reaches stage two
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy2 && v1_q && !hit) |=> !v2_q)
    else $error("out-of-range item entered stage two");

  // Input stalls only when every stage holds an item
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with a free stage");

  // A stage-three item moves to the output when it is free
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy4 && v3_q) |=> v4_q)
    else $error("item lost between stage three and output");

endmodule

@@ verif/tb_text_cell_writer.sv @@
// Self-checking testbench for the text cell writer: random traffic against a local predictor.
module tb_text_cell_writer;
  import tcw_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 10;
  localparam logic [7:0] QuestionMark = 8'h3F;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  cfg_reg_e    cfg_index_i = CFG_COLUMNS;
  logic [31:0] cfg_data_i = '0;

  // Local copy of the screen geometry
  logic [11:0] geo_columns = COLUMNS_RST;
  logic [11:0] geo_rows = ROWS_RST;
  logic [15:0] geo_pitch = ROW_PITCH_RST;
  logic [31:0] geo_base = BUFFER_BASE_RST;

  in_item_t  pending_requests[$];
  out_item_t expected_cells[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;

  text_cell_writer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // 16-color palette, listed in match order
  function automatic logic [23:0] palette_rgb(input int unsigned idx);
    case (idx)
      0:  return 24'h000000;
      1:  return 24'hAA0000;
      2:  return 24'h00AA00;
      3:  return 24'hAA5500;
      4:  return 24'h0000AA;
      5:  return 24'hAA00AA;
      6:  return 24'h00AAAA;
      7:  return 24'hAAAAAA;
      8:  return 24'h555555;
      9:  return 24'hFF5555;
      10: return 24'h55FF55;
      11: return 24'hFFFF55;
      12: return 24'h5555FF;
      13: return 24'hFF55FF;
      14: return 24'h55FFFF;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Swap red and blue bits of the palette index to get the text attribute
  function automatic logic [3:0] attr_of_entry(input int unsigned idx);
    logic [3:0] p;
    p = 4'(idx);
    return {p[3], p[0], p[1], p[2]};
  endfunction

  // Nearest palette entry by summed squared channel error; first minimum wins
  function automatic logic [3:0] nearest_attr(input logic [23:0] rgb);
    int best;
    int sq_sum;
    int dr;
    int dg;
    int db;
    int unsigned pick;
    logic [23:0] ref_rgb;
    best = 32'h7FFF_FFFF;
    pick = 0;
    for (int unsigned i = 0; i < 16; i++) begin
      ref_rgb = palette_rgb(i);
      dr = int'(rgb[23:16]) - int'(ref_rgb[23:16]);
      dg = int'(rgb[15:8]) - int'(ref_rgb[15:8]);
      db = int'(rgb[7:0]) - int'(ref_rgb[7:0]);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum < best) begin
        best = sq_sum;
        pick = i;
      end
    end
    return attr_of_entry(pick);
  endfunction

  // Predict the cell write for one request; returns 0 when the position is off screen
  function automatic bit predict_cell_write(input in_item_t req, output out_item_t pred_cell);
    logic [7:0] ch;
    pred_cell = '0;
    if (req.column >= geo_columns || req.row >= geo_rows) return 1'b0;
    ch = (req.char_code >= 16'h0100) ? QuestionMark : req.char_code[7:0];
    pred_cell.cell_word = {nearest_attr(req.back_rgb), nearest_attr(req.fore_rgb), ch};
    pred_cell.cell_address = geo_base + 32'(req.row) * 32'(geo_pitch)
                           + 32'(req.column) * 32'd2;
    return 1'b1;
  endfunction

  // Channel values on and between palette levels, ties included
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'h2A;
      2: return 8'h2B;
      3: return 8'h55;
      4: return 8'h7F;
      5: return 8'h80;
      6: return 8'hAA;
      7: return 8'hD4;
      8: return 8'hD5;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [23:0] pick_color();
    case ($urandom_range(0, 3))
      0, 1: return 24'($urandom);
      2: return {pick_channel(), pick_channel(), pick_channel()};
      default: return palette_rgb($urandom_range(0, 15));
    endcase
  endfunction

  // Mostly on screen, with the last slot, the first slot past it and wild values mixed in
  function automatic logic [11:0] pick_coord(input logic [11:0] limit);
    if (limit == 0) return 12'($urandom);
    case ($urandom_range(0, 9))
      0: return 12'($urandom);
      1: return limit - 12'd1;
      2: return limit;
      default: return 12'($urandom_range(0, int'(limit) - 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: return 16'h0000;
      3: return 16'h00FF;
      4: return 16'h0100;
      5: return 16'hFFFF;
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_request(input logic [15:0] ch, input logic [11:0] col,
                               input logic [11:0] row, input logic [23:0] fg,
                               input logic [23:0] bg);
    in_item_t req;
    req.char_code = ch;
    req.column = col;
    req.row = row;
    req.fore_rgb = fg;
    req.back_rgb = bg;
    pending_requests.push_back(req);
  endtask

  task automatic queue_random_requests(input int unsigned count);
    @(negedge clk_i);
    repeat (count) begin
      queue_request(pick_char(), pick_coord(geo_columns), pick_coord(geo_rows),
                    pick_color(), pick_color());
    end
  endtask

  // Hold until every item is taken, every cell has come out and the pipe is empty
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_cells.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_COLUMNS:   geo_columns = value[11:0];
      CFG_ROWS:      geo_rows = value[11:0];
      CFG_ROW_PITCH: geo_pitch = value[15:0];
      default:       geo_base = value;
    endcase
  endtask

  // Narrow registers get junk above their width, which must be dropped
  task automatic set_geometry(input logic [11:0] cols, input logic [11:0] rows,
                              input logic [15:0] pitch, input logic [31:0] base);
    write_reg(CFG_COLUMNS, {20'($urandom), cols});
    write_reg(CFG_ROWS, {20'($urandom), rows});
    write_reg(CFG_ROW_PITCH, {16'($urandom), pitch});
    write_reg(CFG_BUFFER_BASE, base);
  endtask

  // Driver: record accepted items, present the next one in bursts with gaps
  always @(posedge clk_i) begin : drive_proc
    logic      next_valid;
    in_item_t  next_item;
    out_item_t pred_cell;
    next_valid = in_valid_i;
    next_item = in_item_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (predict_cell_write(in_item_i, pred_cell)) expected_cells.push_back(pred_cell);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0) begin
          next_item = pending_requests.pop_front();
          next_valid = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end else begin
      next_valid = 1'b0;
    end
    in_valid_i <= next_valid;
    in_item_i <= next_item;
  end

  // Monitor: check each accepted cell against the oldest prediction, stall in segments
  always @(posedge clk_i) begin : monitor_proc
    out_item_t want;
    logic      next_stall;
    next_stall = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: unexpected cell write: expected none, actual addr %h word %h",
                   $time, out_item_o.cell_address, out_item_o.cell_word);
          error_count++;
        end else begin
          want = expected_cells.pop_front();
          if (out_item_o.cell_address !== want.cell_address) begin
            $display("%0t: cell_address mismatch: expected %h, actual %h",
                     $time, want.cell_address, out_item_o.cell_address);
            error_count++;
          end
          if (out_item_o.cell_word !== want.cell_word) begin
            $display("%0t: cell_word mismatch: expected %h, actual %h",
                     $time, want.cell_word, out_item_o.cell_word);
            error_count++;
          end
        end
      end
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(4, 40);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0: next_stall = 1'b0;
        1: next_stall = ($urandom_range(0, 3) == 0);
        2: next_stall = ($urandom_range(0, 3) != 0);
        default: next_stall = 1'b1;
      endcase
    end
    out_stall_i <= next_stall;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d cells outstanding", $time, expected_cells.size());
      $display("tb_text_cell_writer failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corners, dropped positions, substitution, ties, every palette entry
    @(negedge clk_i);
    queue_request(16'h0000, 12'd0, 12'd0, 24'h000000, 24'h000000);
    queue_request(16'h00FF, 12'd79, 12'd24, 24'hFFFFFF, 24'hFFFFFF);
    queue_request(16'h0041, 12'd80, 12'd0, 24'h123456, 24'h654321);
    queue_request(16'h0041, 12'd0, 12'd25, 24'h123456, 24'h654321);
    queue_request(16'hFFFF, 12'd4095, 12'd4095, 24'hFFFFFF, 24'h000000);
    queue_request(16'h0100, 12'd1, 12'd1, 24'h000055, 24'h7F7F7F);
    queue_request(16'hFFFF, 12'd2, 12'd3, 24'hD5D5D5, 24'h2A2B2A);
    for (int unsigned i = 0; i < 16; i++) begin
      queue_request(16'(i * 17), 12'(i * 5), 12'(i), palette_rgb(i), palette_rgb(15 - i));
    end
    wait_drained();

    // Default geometry, with a full pause halfway through
    queue_random_requests(80);
    wait_drained();
    queue_random_requests(85);
    wait_drained();

    // Largest geometry, address wraps past the top
    set_geometry(12'd4095, 12'd4095, 16'hFFFF, 32'hFFFF_FFFF);
    queue_random_requests(165);
    wait_drained();

    // Smallest geometry
    set_geometry(12'd1, 12'd1, 16'd2, 32'h0000_0000);
    queue_random_requests(165);
    wait_drained();

    // No columns, then no rows: nothing lands on screen
    set_geometry(12'd0, 12'd25, 16'd160, 32'h000B_8000);
    queue_random_requests(20);
    wait_drained();
    set_geometry(12'd80, 12'd0, 16'd160, 32'h000B_8000);
    queue_random_requests(20);
    wait_drained();

    // Assorted geometries, mostly modest, some wide
    repeat (5) begin
      if ($urandom_range(0, 1) == 0) begin
        set_geometry(12'($urandom_range(1, 200)), 12'($urandom_range(1, 100)),
                     16'($urandom_range(2, 1024)), $urandom);
      end else begin
        set_geometry(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                     16'($urandom_range(2, 65535)), $urandom);
      end
      queue_random_requests(165);
      wait_drained();
    end

    if (error_count == 0 && expected_cells.size() == 0) begin
      $display("tb_text_cell_writer passed");
    end else begin
      $display("tb_text_cell_writer failed");
    end
    $finish;
  end

endmodule

@@ text_cell_writer.f @@
design/tcw_pkg.sv
design/tcw_lane.sv
design/tcw_merge.sv
design/text_cell_writer.sv
verif/tb_text_cell_writer.sv
